// File: sv/wsw_pkg.sv
// ----------------------------------------------------------------------------
// wsw_pkg: shared types and constants of the worker stall watchdog
// Field widths, beat layouts, action kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
package wsw_pkg;

    localparam int NUM_WORKERS_DEF = 32;

    localparam int TIME_W   = 64;
    localparam int DEPTH_W  = 16;
    localparam int IDX_W    = 5;
    localparam int ACT_W    = 3;
    localparam int STATE_W  = 2;

    // slave beat: tdata layout (tuser carries the action, tlast the pass end)
    localparam int IN_IDX_LSB    = 0;
    localparam int IN_NOW_LSB    = IN_IDX_LSB + IDX_W;
    localparam int IN_DEPTH_LSB  = IN_NOW_LSB + TIME_W;
    localparam int IN_OLDEST_LSB = IN_DEPTH_LSB + DEPTH_W;
    localparam int IN_USED_W     = IN_OLDEST_LSB + TIME_W;
    localparam int S_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;

    // master beat: tdata layout
    localparam int OUT_STALLED   = 0;
    localparam int OUT_NEWLY     = 1;
    localparam int OUT_STATE_LSB = 2;
    localparam int OUT_HB_LSB    = OUT_STATE_LSB + STATE_W;
    localparam int OUT_EV_LSB    = OUT_HB_LSB + TIME_W;
    localparam int OUT_PING      = OUT_EV_LSB + TIME_W;
    localparam int OUT_USED_W    = OUT_PING + 1;
    localparam int M_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TIME_W;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKLOG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WATCHDOG_ENABLED  = 2'd2;

    localparam logic [TIME_W-1:0]  STALL_TIMEOUT_RST     = 64'd3000000000;
    localparam logic [DEPTH_W-1:0] BACKLOG_THRESHOLD_RST = 16'd5;
    localparam logic               WATCHDOG_ENABLED_RST  = 1'b0;

    // action codes as they arrive on tuser
    localparam logic [ACT_W-1:0] ACT_INIT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BEAT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BEGIN = 3'd2;
    localparam logic [ACT_W-1:0] ACT_END   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CHECK = 3'd4;

    // worker state codes reported on the result
    localparam logic [STATE_W-1:0] WS_IDLE    = 2'd0;
    localparam logic [STATE_W-1:0] WS_BUSY    = 2'd1;
    localparam logic [STATE_W-1:0] WS_STALLED = 2'd2;

    // classified action kind, unused codes fold into KIND_NOP
    typedef enum logic [2:0] {
        KIND_INIT,
        KIND_BEAT,
        KIND_BEGIN,
        KIND_END,
        KIND_CHECK,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        logic [TIME_W-1:0]  stall_timeout;
        logic [DEPTH_W-1:0] backlog_threshold;
        logic               watchdog_enabled;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic               in_range;
        logic [IDX_W-1:0]   worker_index;
        logic [TIME_W-1:0]  now_time;
        logic [DEPTH_W-1:0] backlog_len;
        logic [TIME_W-1:0]  oldest_queued_age;
        logic               pass_last;
    } cmd_t;

    // handshake between the front queue and the back end
    typedef struct packed {
        logic head_valid;
    } q_status_t;

    typedef struct packed {
        logic pop;
        logic accept_en;
    } back_ctrl_t;

endpackage

// File: sv/wsw_ram.sv
// ----------------------------------------------------------------------------
// wsw_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/wsw_front.sv
// ----------------------------------------------------------------------------
// wsw_front: input side of the worker stall watchdog
// Accept beats, classify the action and the worker slot, hold them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wsw_front #(
    parameter int NUM_WORKERS = wsw_pkg::NUM_WORKERS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [wsw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [wsw_pkg::ACT_W-1:0]    s_tuser,
    input  logic                         s_tlast,
    input  wsw_pkg::back_ctrl_t          ctrl,
    output wsw_pkg::q_status_t           status,
    output wsw_pkg::cmd_t                head
);

    localparam int QDEPTH = 2;

    wsw_pkg::cmd_t q_reg [QDEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    wsw_pkg::cmd_t cmd_in;
    wsw_pkg::kind_t kind_in;
    logic          push;
    logic          pop;

    // classify the action code
    always_comb
    begin
        unique case (s_tuser)
            wsw_pkg::ACT_INIT:  kind_in = wsw_pkg::KIND_INIT;
            wsw_pkg::ACT_BEAT:  kind_in = wsw_pkg::KIND_BEAT;
            wsw_pkg::ACT_BEGIN: kind_in = wsw_pkg::KIND_BEGIN;
            wsw_pkg::ACT_END:   kind_in = wsw_pkg::KIND_END;
            wsw_pkg::ACT_CHECK: kind_in = wsw_pkg::KIND_CHECK;
            default:            kind_in = wsw_pkg::KIND_NOP;
        endcase
    end

    always_comb
    begin
        cmd_in.kind              = kind_in;
        cmd_in.worker_index      = s_tdata[wsw_pkg::IN_IDX_LSB +: wsw_pkg::IDX_W];
        cmd_in.in_range          = 32'(cmd_in.worker_index) < 32'(NUM_WORKERS);
        cmd_in.now_time          = s_tdata[wsw_pkg::IN_NOW_LSB +: wsw_pkg::TIME_W];
        cmd_in.backlog_len       = s_tdata[wsw_pkg::IN_DEPTH_LSB +: wsw_pkg::DEPTH_W];
        cmd_in.oldest_queued_age = s_tdata[wsw_pkg::IN_OLDEST_LSB +: wsw_pkg::TIME_W];
        cmd_in.pass_last         = s_tlast;
    end

    assign s_tready = ctrl.accept_en && (count_reg != 2'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = ctrl.pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head              = q_reg[rd_ptr_reg];
    assign status.head_valid = count_reg != 2'd0;

endmodule

// File: sv/wsw_back.sv
// ----------------------------------------------------------------------------
// wsw_back: execution side of the worker stall watchdog
// Read the worker slot, apply the action, judge stalls, write the slot back
// and present the result beat. Clear the slot table after reset.
// ----------------------------------------------------------------------------
module wsw_back #(
    parameter int NUM_WORKERS = wsw_pkg::NUM_WORKERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsw_pkg::cfg_t                 cfg,
    input  wsw_pkg::q_status_t            status,
    input  wsw_pkg::cmd_t                 head,
    output wsw_pkg::back_ctrl_t           ctrl,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wsw_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int TW = wsw_pkg::TIME_W;
    localparam int EW = 2 * TW + 1;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_ISSUE,
        ST_AGE,
        ST_JUDGE
    } state_t;

    state_t                        state_reg;
    logic [AW-1:0]                 sweep_reg;
    wsw_pkg::cmd_t                 cur_reg;
    logic [TW-1:0]                 hb_reg, ev_reg;
    logic                          latch_reg;
    logic [TW-1:0]                 hb_age_reg, ev_age_reg;
    logic                          pass_healthy_reg;
    logic                          m_tvalid_reg;
    logic [wsw_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [TW-1:0] rd_hb, rd_ev;
    logic          rd_latch;
    logic [TW-1:0] hb_next, ev_next;
    logic          latch_next;
    logic [TW-1:0] hb_age_next, ev_age_next;

    logic                          is_check, busy, stall, latch_new, newly;
    logic                          healthy, ping, pass_healthy_next, out_free;
    logic [wsw_pkg::STATE_W-1:0]   wstate;
    logic [wsw_pkg::M_TDATA_W-1:0] m_tdata_next;

    wsw_ram #(
        .WIDTH(EW),
        .DEPTH(NUM_WORKERS)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // apply the action to the slot read back from the table
    always_comb
    begin
        rd_hb      = ram_rdata[TW-1:0];
        rd_ev      = ram_rdata[2*TW-1:TW];
        rd_latch   = ram_rdata[2*TW];
        hb_next    = rd_hb;
        ev_next    = rd_ev;
        latch_next = rd_latch;
        unique case (cur_reg.kind)
            wsw_pkg::KIND_INIT:
            begin
                hb_next    = cur_reg.now_time;
                ev_next    = '0;
                latch_next = 1'b0;
            end
            wsw_pkg::KIND_BEAT:
            begin
                hb_next = cur_reg.now_time;
            end
            wsw_pkg::KIND_BEGIN:
            begin
                hb_next = cur_reg.now_time;
                ev_next = cur_reg.now_time;
            end
            wsw_pkg::KIND_END:
            begin
                hb_next    = cur_reg.now_time;
                ev_next    = '0;
                latch_next = 1'b0;
            end
            default:
            begin
                hb_next = rd_hb;
            end
        endcase
        // age is zero for an unset stamp or one ahead of now
        hb_age_next = (hb_next != '0 && cur_reg.now_time >= hb_next)
                      ? cur_reg.now_time - hb_next : '0;
        ev_age_next = (ev_next != '0 && cur_reg.now_time >= ev_next)
                      ? cur_reg.now_time - ev_next : '0;
    end

    // stall judgement on the registered ages
    always_comb
    begin
        is_check = cur_reg.kind == wsw_pkg::KIND_CHECK;
        busy     = ev_reg != '0;
        stall    = 1'b0;
        if (cur_reg.in_range && is_check && cfg.stall_timeout != '0)
        begin
            if (busy)
            begin
                stall = (ev_age_reg >= cfg.stall_timeout)
                        && ((cur_reg.backlog_len > cfg.backlog_threshold)
                            || (cur_reg.oldest_queued_age >= cfg.stall_timeout));
            end
            else
            begin
                stall = (cur_reg.backlog_len != '0)
                        && (cur_reg.oldest_queued_age >= cfg.stall_timeout)
                        && (hb_age_reg >= cfg.stall_timeout);
            end
        end
        latch_new = is_check ? stall : latch_reg;
        newly     = stall && !latch_reg;
        healthy   = pass_healthy_reg && !stall;
        ping      = is_check && cur_reg.pass_last && healthy && cfg.watchdog_enabled;
        priority if (is_check && cur_reg.pass_last)
            pass_healthy_next = 1'b1;
        else if (is_check)
            pass_healthy_next = healthy;
        else
            pass_healthy_next = pass_healthy_reg;

        if (!cur_reg.in_range)
            wstate = wsw_pkg::WS_IDLE;
        else if (latch_new)
            wstate = wsw_pkg::WS_STALLED;
        else if (busy)
            wstate = wsw_pkg::WS_BUSY;
        else
            wstate = wsw_pkg::WS_IDLE;

        m_tdata_next = '0;
        m_tdata_next[wsw_pkg::OUT_STALLED] = stall;
        m_tdata_next[wsw_pkg::OUT_NEWLY]   = newly;
        m_tdata_next[wsw_pkg::OUT_STATE_LSB +: wsw_pkg::STATE_W] = wstate;
        m_tdata_next[wsw_pkg::OUT_HB_LSB +: TW] = cur_reg.in_range ? hb_age_reg : '0;
        m_tdata_next[wsw_pkg::OUT_EV_LSB +: TW] = cur_reg.in_range ? ev_age_reg : '0;
        m_tdata_next[wsw_pkg::OUT_PING]    = ping;
    end

    // table access: sweep zeros after reset, otherwise write back on judge
    always_comb
    begin
        ram_raddr = AW'(head.worker_index);
        ram_we    = 1'b0;
        ram_waddr = AW'(cur_reg.worker_index);
        ram_wdata = {latch_new, ev_reg, hb_reg};
        unique case (state_reg)
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = '0;
            end
            ST_JUDGE:
            begin
                ram_we = out_free && cur_reg.in_range;
            end
            ST_ISSUE, ST_AGE:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ctrl.pop       = (state_reg == ST_ISSUE) && status.head_valid;
    assign ctrl.accept_en = state_reg != ST_SWEEP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_SWEEP;
            sweep_reg        <= '0;
            cur_reg          <= '0;
            hb_reg           <= '0;
            ev_reg           <= '0;
            latch_reg        <= 1'b0;
            hb_age_reg       <= '0;
            ev_age_reg       <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            pass_healthy_reg <= 1'b1;
        end
        else
        begin
            priority if ((state_reg == ST_JUDGE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            else
            begin
                m_tvalid_reg <= m_tvalid_reg;
            end
            unique case (state_reg)
                ST_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == AW'(NUM_WORKERS - 1))
                    begin
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (status.head_valid)
                    begin
                        cur_reg   <= head;
                        state_reg <= ST_AGE;
                    end
                end
                ST_AGE:
                begin
                    hb_reg     <= hb_next;
                    ev_reg     <= ev_next;
                    latch_reg  <= latch_next;
                    hb_age_reg <= hb_age_next;
                    ev_age_reg <= ev_age_next;
                    state_reg  <= ST_JUDGE;
                end
                ST_JUDGE:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg      <= m_tdata_next;
                        pass_healthy_reg <= pass_healthy_next;
                        state_reg        <= ST_ISSUE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sv/worker_stall_watchdog.sv
// ----------------------------------------------------------------------------
// worker_stall_watchdog: per-worker progress watchdog
// Flow: one queued beat at a time passes the issue, age and judge steps
//   of the slot table's read-modify-write; the judge step waits while
//   the master holds an untaken result; the front queue buffers new beats.
// Reset: rst_n clears control and loads register defaults, then a sweep
//   zeroes every slot of the slot table; s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module worker_stall_watchdog #(
    parameter int NUM_WORKERS = wsw_pkg::NUM_WORKERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave side
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata from bit 0: worker_index, now_time, backlog_len,
    // oldest_queued_age, zero fill
    input  logic [wsw_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: action
    input  logic [wsw_pkg::ACT_W-1:0]      s_tuser,
    // tlast: pass_last
    input  logic                           s_tlast,
    // master side
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata from bit 0: stalled, newly_stalled, worker_state, heartbeat_age,
    // event_age, watchdog_ping, zero fill
    output logic [wsw_pkg::M_TDATA_W-1:0]  m_tdata,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [wsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    wsw_pkg::cfg_t       cfg_reg;
    wsw_pkg::q_status_t  q_status;
    wsw_pkg::back_ctrl_t back_ctrl;
    wsw_pkg::cmd_t       q_head;

    // Hold the configuration registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stall_timeout     <= wsw_pkg::STALL_TIMEOUT_RST;
            cfg_reg.backlog_threshold <= wsw_pkg::BACKLOG_THRESHOLD_RST;
            cfg_reg.watchdog_enabled  <= wsw_pkg::WATCHDOG_ENABLED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wsw_pkg::REG_STALL_TIMEOUT:
                    cfg_reg.stall_timeout <= cfg_wdata;
                wsw_pkg::REG_BACKLOG_THRESHOLD:
                    cfg_reg.backlog_threshold <= cfg_wdata[wsw_pkg::DEPTH_W-1:0];
                wsw_pkg::REG_WATCHDOG_ENABLED:
                    cfg_reg.watchdog_enabled <= cfg_wdata[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front: accept and classify beats, queue them for the back end.
    wsw_front #(
        .NUM_WORKERS(NUM_WORKERS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .ctrl    (back_ctrl),
        .status  (q_status),
        .head    (q_head)
    );

    // Back: one queued beat at a time through the slot table; the result
    // register frees the back end as soon as the master side takes the beat.
    wsw_back #(
        .NUM_WORKERS(NUM_WORKERS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .status  (q_status),
        .head    (q_head),
        .ctrl    (back_ctrl),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

// File: sv/wsw_checker.sv
// ----------------------------------------------------------------------------
// wsw_checker: port-level checks of the worker stall watchdog
// Result beat consistency and master-side hold, bound to the top level.
// ----------------------------------------------------------------------------
module wsw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wsw_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                        stalled, newly, ping;
    logic [wsw_pkg::STATE_W-1:0] wstate;
    logic [wsw_pkg::TIME_W-1:0]  ev_age;

    assign stalled = m_tdata[wsw_pkg::OUT_STALLED];
    assign newly   = m_tdata[wsw_pkg::OUT_NEWLY];
    assign ping    = m_tdata[wsw_pkg::OUT_PING];
    assign wstate  = m_tdata[wsw_pkg::OUT_STATE_LSB +: wsw_pkg::STATE_W];
    assign ev_age  = m_tdata[wsw_pkg::OUT_EV_LSB +: wsw_pkg::TIME_W];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_newly: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && newly |-> stalled)
        else $error("new stall reported without a stall");

    a_latch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && stalled |-> wstate == wsw_pkg::WS_STALLED)
        else $error("stalled worker not shown as latched");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ev_age != '0 |-> wstate != wsw_pkg::WS_IDLE)
        else $error("running event on a worker shown idle");

    a_ping: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ping |-> !stalled)
        else $error("watchdog ping on a stalled check");

endmodule

bind worker_stall_watchdog wsw_checker u_wsw_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// File: tb/tb_worker_stall_watchdog.sv
// ----------------------------------------------------------------------------
// tb_worker_stall_watchdog: self-checking bench of the worker stall watchdog
// Drives action beats with bursty gaps, stalls the result side on a pattern
// of its own, predicts each result beat from a slot-table model and compares
// it field by field. Register settings change between phases of traffic.
// ----------------------------------------------------------------------------
module tb_worker_stall_watchdog;

    localparam int N_SLOTS     = wsw_pkg::NUM_WORKERS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    localparam int ACT_W     = wsw_pkg::ACT_W;
    localparam int IDX_W     = wsw_pkg::IDX_W;
    localparam int TIME_W    = wsw_pkg::TIME_W;
    localparam int DEPTH_W   = wsw_pkg::DEPTH_W;
    localparam int STATE_W   = wsw_pkg::STATE_W;
    localparam int S_TDATA_W = wsw_pkg::S_TDATA_W;
    localparam int M_TDATA_W = wsw_pkg::M_TDATA_W;
    localparam int CFG_IDX_W = wsw_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = wsw_pkg::CFG_DATA_W;

    // codes 5..7 carry no action; the block must treat them as no-ops
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = wsw_pkg::ACT_CHECK + 3'd1;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = '1;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [IDX_W-1:0]   worker;
        logic [TIME_W-1:0]  now_stamp;
        logic [DEPTH_W-1:0] depth;
        logic [TIME_W-1:0]  oldest_age;
        logic               pass_end;
    } watch_item_t;

    typedef struct packed {
        logic               stalled;
        logic               newly;
        logic [STATE_W-1:0] state;
        logic [TIME_W-1:0]  hb_age;
        logic [TIME_W-1:0]  ev_age;
        logic               ping;
    } verdict_t;

    // ------------------------------------------------------------------------
    // Slot-table model: holds its own copy of the table and registers, turns
    // each accepted beat into the verdict it must produce, and compares the
    // result beats against the oldest verdict still awaited.
    // ------------------------------------------------------------------------
    class stall_judge;
        logic [TIME_W-1:0]  hb_stamp [N_SLOTS];
        logic [TIME_W-1:0]  ev_stamp [N_SLOTS];
        logic               latched  [N_SLOTS];
        logic               pass_ok;
        logic [TIME_W-1:0]  timeout;
        logic [DEPTH_W-1:0] backlog;
        logic               ping_en;
        verdict_t           awaited_verdicts [$];
        int                 failures;

        function new();
            for (int i = 0; i < N_SLOTS; i++)
            begin
                hb_stamp[i] = '0;
                ev_stamp[i] = '0;
                latched[i]  = 1'b0;
            end
            pass_ok  = 1'b1;
            timeout  = wsw_pkg::STALL_TIMEOUT_RST;
            backlog  = wsw_pkg::BACKLOG_THRESHOLD_RST;
            ping_en  = wsw_pkg::WATCHDOG_ENABLED_RST;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx,
                                logic [CFG_DAT_W-1:0] data);
            case (idx)
                wsw_pkg::REG_STALL_TIMEOUT:     timeout = data;
                wsw_pkg::REG_BACKLOG_THRESHOLD: backlog = data[DEPTH_W-1:0];
                wsw_pkg::REG_WATCHDOG_ENABLED:  ping_en = data[0];
                default: ;
            endcase
        endfunction

        // zero stamp means unset, a stamp ahead of now gives no age
        function logic [TIME_W-1:0] age_at(logic [TIME_W-1:0] now_v,
                                           logic [TIME_W-1:0] stamp);
            if (stamp == '0 || now_v < stamp)
                return '0;
            return now_v - stamp;
        endfunction

        function int awaited();
            return awaited_verdicts.size();
        endfunction

        // every 5-bit index lies inside the 32-slot table
        function void note_item(watch_item_t it);
            verdict_t v;
            logic     judged;
            int       w;
            v = '0;
            w = it.worker;
            case (it.action)
                wsw_pkg::ACT_INIT:
                begin
                    hb_stamp[w] = it.now_stamp;
                    ev_stamp[w] = '0;
                    latched[w]  = 1'b0;
                end
                wsw_pkg::ACT_BEAT:  hb_stamp[w] = it.now_stamp;
                wsw_pkg::ACT_BEGIN:
                begin
                    ev_stamp[w] = it.now_stamp;
                    hb_stamp[w] = it.now_stamp;
                end
                wsw_pkg::ACT_END:
                begin
                    ev_stamp[w] = '0;
                    hb_stamp[w] = it.now_stamp;
                    latched[w]  = 1'b0;
                end
                default: ;
            endcase
            v.hb_age = age_at(it.now_stamp, hb_stamp[w]);
            v.ev_age = age_at(it.now_stamp, ev_stamp[w]);
            if (it.action == wsw_pkg::ACT_CHECK)
            begin
                judged = 1'b0;
                if (timeout != '0)
                begin
                    if (ev_stamp[w] != '0)
                        judged = v.ev_age >= timeout &&
                                 (it.depth > backlog || it.oldest_age >= timeout);
                    else
                        judged = it.depth != '0 && it.oldest_age >= timeout &&
                                 v.hb_age >= timeout;
                end
                if (judged)
                begin
                    v.stalled  = 1'b1;
                    v.newly    = !latched[w];
                    latched[w] = 1'b1;
                    pass_ok    = 1'b0;
                end
                else
                    latched[w] = 1'b0;
            end
            if (latched[w])
                v.state = wsw_pkg::WS_STALLED;
            else if (ev_stamp[w] != '0)
                v.state = wsw_pkg::WS_BUSY;
            else
                v.state = wsw_pkg::WS_IDLE;
            if (it.action == wsw_pkg::ACT_CHECK && it.pass_end)
            begin
                v.ping  = pass_ok && ping_en;
                pass_ok = 1'b1;
            end
            awaited_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic [M_TDATA_W-1:0] beat);
            verdict_t got;
            verdict_t exp_v;
            got.stalled = beat[wsw_pkg::OUT_STALLED];
            got.newly   = beat[wsw_pkg::OUT_NEWLY];
            got.state   = beat[wsw_pkg::OUT_STATE_LSB +: STATE_W];
            got.hb_age  = beat[wsw_pkg::OUT_HB_LSB +: TIME_W];
            got.ev_age  = beat[wsw_pkg::OUT_EV_LSB +: TIME_W];
            got.ping    = beat[wsw_pkg::OUT_PING];
            if (awaited_verdicts.size() == 0)
            begin
                $display("%0t: result beat with none awaited, actual %h", $time, beat);
                failures++;
                return;
            end
            exp_v = awaited_verdicts.pop_front();
            if (got.stalled !== exp_v.stalled)
            begin
                $display("%0t: stalled expected %0d actual %0d",
                         $time, exp_v.stalled, got.stalled);
                failures++;
            end
            if (got.newly !== exp_v.newly)
            begin
                $display("%0t: newly_stalled expected %0d actual %0d",
                         $time, exp_v.newly, got.newly);
                failures++;
            end
            if (got.state !== exp_v.state)
            begin
                $display("%0t: worker_state expected %0d actual %0d",
                         $time, exp_v.state, got.state);
                failures++;
            end
            if (got.hb_age !== exp_v.hb_age)
            begin
                $display("%0t: heartbeat_age expected %h actual %h",
                         $time, exp_v.hb_age, got.hb_age);
                failures++;
            end
            if (got.ev_age !== exp_v.ev_age)
            begin
                $display("%0t: event_age expected %h actual %h",
                         $time, exp_v.ev_age, got.ev_age);
                failures++;
            end
            if (got.ping !== exp_v.ping)
            begin
                $display("%0t: watchdog_ping expected %0d actual %0d",
                         $time, exp_v.ping, got.ping);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports, the bench-driven ones known from time zero
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // tdata from bit 0: worker_index, now_time, backlog_len,
    // oldest_queued_age, zero fill
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    // tuser: action
    logic [ACT_W-1:0]      s_tuser   = wsw_pkg::ACT_INIT;
    // tlast: pass_last
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // tdata from bit 0: stalled, newly_stalled, worker_state, heartbeat_age,
    // event_age, watchdog_ping, zero fill
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = wsw_pkg::REG_STALL_TIMEOUT;
    logic [CFG_DAT_W-1:0]  cfg_wdata = '0;

    stall_judge judge = new();

    // stimulus shaping state
    int                burst_left = 0;
    logic [TIME_W-1:0] clock_now  = 64'd1;
    int unsigned       step_max   = 30;
    int unsigned       age_span   = 200;
    int                cycle_count = 0;

    worker_stall_watchdog #(.NUM_WORKERS(N_SLOTS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold the run to a hard cycle budget; a hung handshake ends here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted beat, then pick the next tready.
    // The stall pattern switches between free flow, coin flips and long
    // stalls, each mode lasting a random stretch of cycles.
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int rx_mode;
        int mode_left;
        rx_mode   = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready)
                judge.check_verdict(m_tdata);
            if (mode_left == 0)
            begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 11) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Action side
    // ------------------------------------------------------------------------
    function automatic watch_item_t beat_of(logic [ACT_W-1:0] act, int w,
                                            logic [TIME_W-1:0] now_v,
                                            logic [DEPTH_W-1:0] depth,
                                            logic [TIME_W-1:0] oldest,
                                            logic last);
        watch_item_t it;
        it.action     = act;
        it.worker     = w[IDX_W-1:0];
        it.now_stamp  = now_v;
        it.depth      = depth;
        it.oldest_age = oldest;
        it.pass_end   = last;
        return it;
    endfunction

    // Mostly advance the phase clock by a small step; now and then jump
    // backward (stamp ahead of now), to zero, to all ones or anywhere.
    function automatic watch_item_t make_item(logic [ACT_W-1:0] act, int w, logic last);
        logic [TIME_W-1:0]  now_v;
        logic [DEPTH_W-1:0] depth;
        logic [TIME_W-1:0]  oldest;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            clock_now = clock_now + 64'($urandom_range(0, step_max));
            now_v     = clock_now;
        end
        else if (r < 90)
            now_v = clock_now - 64'($urandom_range(0, step_max));
        else if (r < 96)
            now_v = {$urandom, $urandom};
        else if (r < 98)
            now_v = '0;
        else
            now_v = '1;
        depth  = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 8))
                                             : 16'($urandom_range(0, 65535));
        oldest = ($urandom_range(0, 4) != 0) ? 64'($urandom_range(0, age_span))
                                             : {$urandom, $urandom};
        return beat_of(act, w, now_v, depth, oldest, last);
    endfunction

    // Present one beat, hold it until accepted, then hand it to the model.
    // Bursts of random length alternate with random idle gaps.
    task automatic push_beat(input watch_item_t it);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        word = '0;
        word[wsw_pkg::IN_IDX_LSB +: IDX_W]      = it.worker;
        word[wsw_pkg::IN_NOW_LSB +: TIME_W]     = it.now_stamp;
        word[wsw_pkg::IN_DEPTH_LSB +: DEPTH_W]  = it.depth;
        word[wsw_pkg::IN_OLDEST_LSB +: TIME_W]  = it.oldest_age;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= it.action;
        s_tlast  <= it.pass_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        judge.note_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        judge.write_reg(idx, data);
    endtask

    // Drop valid, drain every awaited verdict, then load all three registers.
    // Junk above the register width checks that the block masks it.
    task automatic enter_phase(input logic [TIME_W-1:0] tmo,
                               input logic [DEPTH_W-1:0] thr,
                               input logic en,
                               input int unsigned step,
                               input int unsigned span);
        s_tvalid <= 1'b0;
        while (judge.awaited() != 0)
            @(posedge clk);
        write_reg(wsw_pkg::REG_STALL_TIMEOUT, tmo);
        write_reg(wsw_pkg::REG_BACKLOG_THRESHOLD, {$urandom, 16'($urandom), thr});
        write_reg(wsw_pkg::REG_WATCHDOG_ENABLED, {$urandom, 31'($urandom), en});
        cfg_we   <= 1'b0;
        step_max  = step;
        age_span  = span;
    endtask

    task automatic run_directed();
        // reset settings: long timeout, ping off
        push_beat(beat_of(wsw_pkg::ACT_INIT, 0, 64'd1000, 16'd0, 64'd0, 1'b0));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 0, 64'd3000001000, 16'd1,
                          64'd3000000000, 1'b1));
        // stamp ahead of now: no age, latch clears
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 0, 64'd1, 16'd1, 64'd3000000000, 1'b1));

        enter_phase(64'd100, 16'd5, 1'b1, 30, 200);
        // init at time zero leaves the heartbeat unset
        push_beat(beat_of(wsw_pkg::ACT_INIT, 1, 64'd0, 16'd0, 64'd0, 1'b0));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 1, 64'd500, 16'd1, 64'd200, 1'b0));
        // busy stall by backlog, then again by oldest age without a new report
        push_beat(beat_of(wsw_pkg::ACT_BEGIN, 2, 64'd1000, 16'd0, 64'd0, 1'b0));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 2, 64'd1200, 16'd6, 64'd0, 1'b0));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 2, 64'd1300, 16'd0, 64'd100, 1'b0));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 3, 64'd1300, 16'd0, 64'd0, 1'b1));
        // event end clears; a clean pass pings
        push_beat(beat_of(wsw_pkg::ACT_END, 2, 64'd1400, 16'd0, 64'd0, 1'b1));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 2, 64'd1401, 16'd9, '1, 1'b1));
        // idle stall with a stale heartbeat
        push_beat(beat_of(wsw_pkg::ACT_BEAT, 3, 64'd2000, 16'd0, 64'd0, 1'b0));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 3, 64'd2100, 16'd1, 64'd100, 1'b0));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 3, 64'd1500, 16'd1, 64'd100, 1'b1));
        // event begun at time zero counts as idle
        push_beat(beat_of(wsw_pkg::ACT_BEGIN, 4, 64'd0, 16'd0, 64'd0, 1'b0));
        // spare codes, some with pass end set: no state change, no ping
        push_beat(beat_of(ACT_SPARE_FIRST, 5, 64'd2200, 16'hFFFF, '1, 1'b1));
        push_beat(beat_of(ACT_SPARE_FIRST + 3'd1, 31, 64'd2300, 16'd0, 64'd0, 1'b0));
        push_beat(beat_of(ACT_SPARE_LAST, 16, '1, 16'hFFFF, '1, 1'b1));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 31, '1, 16'hFFFF, '1, 1'b1));
        push_beat(beat_of(wsw_pkg::ACT_BEGIN, 2, 64'd10, 16'd0, 64'd0, 1'b0));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 2, 64'd1000, 16'd6, 64'd0, 1'b0));

        // zero timeout disables detection and clears the latch
        enter_phase(64'd0, 16'd0, 1'b1, 50, 100);
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 2, 64'd5000, 16'hFFFF, '1, 1'b1));

        // widest timeout and threshold
        enter_phase('1, 16'hFFFF, 1'b0, 30, 100);
        push_beat(beat_of(wsw_pkg::ACT_BEGIN, 6, 64'd1, 16'd0, 64'd0, 1'b0));
        push_beat(beat_of(wsw_pkg::ACT_CHECK, 6, '1, 16'hFFFF, '1, 1'b1));
    endtask

    // Random traffic: mostly check passes over a few workers and event
    // lifetimes (begin, checks, end), the rest loose beats of any code.
    task automatic run_random(input int n_items);
        int sent;
        int kind_pick;
        int k;
        int w;
        sent = 0;
        while (sent < n_items)
        begin
            kind_pick = $urandom_range(0, 9);
            if (kind_pick < 4)
            begin
                k = $urandom_range(1, 8);
                for (int i = 0; i < k; i++)
                    push_beat(make_item(wsw_pkg::ACT_CHECK,
                                        $urandom_range(0, N_SLOTS - 1), i == k - 1));
                sent += k;
            end
            else if (kind_pick < 7)
            begin
                w = $urandom_range(0, N_SLOTS - 1);
                push_beat(make_item(wsw_pkg::ACT_BEGIN, w, 1'($urandom_range(0, 1))));
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++)
                    push_beat(make_item(wsw_pkg::ACT_CHECK, w, 1'($urandom_range(0, 1))));
                sent += k + 1;
                if ($urandom_range(0, 3) != 0)
                begin
                    push_beat(make_item(wsw_pkg::ACT_END, w, 1'($urandom_range(0, 1))));
                    sent++;
                end
            end
            else if (kind_pick < 9)
            begin
                push_beat(make_item(3'($urandom_range(0, ACT_SPARE_LAST)),
                                    $urandom_range(0, N_SLOTS - 1),
                                    1'($urandom_range(0, 1))));
                sent++;
            end
            else
            begin
                push_beat(make_item($urandom_range(0, 1) ? wsw_pkg::ACT_BEAT
                                                         : wsw_pkg::ACT_INIT,
                                    $urandom_range(0, N_SLOTS - 1),
                                    1'($urandom_range(0, 1))));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        enter_phase(64'd100, 16'd5, 1'b1, 30, 200);
        run_random(350);
        enter_phase(64'd1000, 16'd2, 1'b1, 200, 2000);
        run_random(300);
        enter_phase(64'd0, 16'd0, 1'b1, 50, 100);
        run_random(150);
        enter_phase('1, 16'hFFFF, 1'b0, 30, 100);
        run_random(150);
        enter_phase({$urandom, $urandom}, 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 30, 100);
        run_random(150);
        // smallest live timeout: nearly every check can trip
        enter_phase(64'd1, 16'd0, 1'b1, 3, 3);
        run_random(150);
        enter_phase(64'd50, 16'd3, 1'b0, 20, 120);
        run_random(300);

        // drain, then give stray beats a chance to show up
        s_tvalid <= 1'b0;
        while (judge.awaited() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (judge.failures == 0 && judge.awaited() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
sv/wsw_pkg.sv
sv/wsw_ram.sv
sv/wsw_front.sv
sv/wsw_back.sv
sv/worker_stall_watchdog.sv
sv/wsw_checker.sv
tb/tb_worker_stall_watchdog.sv
